// File: rtl/core/button_press_classifier_defines.svh
// ---------------------------------------------------------------------------
// Button press classifier assertion macros
// Shared property templates for the checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef BUTTON_PRESS_CLASSIFIER_DEFINES_SVH
`define BUTTON_PRESS_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BPC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("button_press_classifier: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define BPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("button_press_classifier: next-cycle check failed");

`endif

// File: rtl/core/bpc_pkg.sv
// ---------------------------------------------------------------------------
// Button press classifier package
// Request and result types, configuration type, operation codes and resets.
// ---------------------------------------------------------------------------
package bpc_pkg;

  localparam logic [2:0] OP_TICK        = 3'd0;
  localparam logic [2:0] OP_READ_SHORT  = 3'd1;
  localparam logic [2:0] OP_READ_LONG   = 3'd2;
  localparam logic [2:0] OP_READ_DOUBLE = 3'd3;
  localparam logic [2:0] OP_READ_ALT    = 3'd4;

  localparam logic [1:0] REG_SAMPLE_DIV    = 2'd0;
  localparam logic [1:0] REG_DOUBLE_WINDOW = 2'd1;
  localparam logic [1:0] REG_LONG_SAMPLES  = 2'd2;

  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [7:0]  SAMPLE_DIV_RESET    = 8'd20;
  localparam logic [15:0] DOUBLE_WINDOW_RESET = 16'd900;
  localparam logic [7:0]  LONG_SAMPLES_RESET  = 8'd60;

  localparam logic [1:0] ALT_FIRST  = 2'd1;
  localparam logic [1:0] ALT_SECOND = 2'd2;

  typedef struct packed {
    logic [2:0] op;
    logic       pin_level;
  } in_item_t;

  typedef struct packed {
    logic [1:0] read_value;
    logic       short_pending;
    logic       long_pending;
    logic       double_pending;
    logic       key_sampled;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  sample_div;
    logic [15:0] double_window;
    logic [7:0]  long_samples;
  } cfg_t;

endpackage

// File: rtl/core/bpc_cfg_regs.sv
// ---------------------------------------------------------------------------
// Button press classifier configuration registers
// Write-only register file for sample divider, double window and long count.
// ---------------------------------------------------------------------------
module bpc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data,
  output bpc_pkg::cfg_t                 cfg
);
  import bpc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_div    <= SAMPLE_DIV_RESET;
      cfg.double_window <= DOUBLE_WINDOW_RESET;
      cfg.long_samples  <= LONG_SAMPLES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SAMPLE_DIV:    cfg.sample_div    <= cfg_data[7:0];
        REG_DOUBLE_WINDOW: cfg.double_window <= cfg_data[15:0];
        REG_LONG_SAMPLES:  cfg.long_samples  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/bpc_core.sv
// ---------------------------------------------------------------------------
// Button press classifier core
// Classification state and its combinational update for one request.
// ---------------------------------------------------------------------------
module bpc_core (
  input  logic               clk,
  input  logic               rst,
  input  bpc_pkg::cfg_t      cfg,
  input  logic               fire,
  input  bpc_pkg::in_item_t  item,
  output bpc_pkg::out_item_t result
);
  import bpc_pkg::*;

  logic [7:0]  sample_counter, sample_counter_next;
  logic [15:0] since_short, since_short_next;
  logic        prev_pressed, prev_pressed_next;
  logic        cur_pressed, cur_pressed_next;
  logic        suppress_release, suppress_release_next;
  logic [7:0]  held_samples, held_samples_next;
  logic        short_flag, short_flag_next;
  logic        long_flag, long_flag_next;
  logic        double_flag, double_flag_next;
  logic        alternate_parity, alternate_parity_next;
  logic [1:0]  read_value;

  always_comb begin
    logic [7:0]  sc_inc;
    logic [15:0] ss_inc;
    logic [7:0]  held_upd;
    sample_counter_next   = sample_counter;
    since_short_next      = since_short;
    prev_pressed_next     = prev_pressed;
    cur_pressed_next      = cur_pressed;
    suppress_release_next = suppress_release;
    held_samples_next     = held_samples;
    short_flag_next       = short_flag;
    long_flag_next        = long_flag;
    double_flag_next      = double_flag;
    alternate_parity_next = alternate_parity;
    read_value            = 2'd0;
    sc_inc   = (sample_counter != 8'hFF) ? sample_counter + 8'd1 : sample_counter;
    ss_inc   = (since_short != 16'hFFFF) ? since_short + 16'd1 : since_short;
    held_upd = held_samples;

    case (item.op)
      OP_TICK: begin
        sample_counter_next = sc_inc;
        since_short_next    = ss_inc;
        if (sc_inc >= cfg.sample_div) begin
          sample_counter_next   = 8'd0;
          // A release that ends a long press is seen as no prior press.
          prev_pressed_next     = suppress_release ? 1'b0 : cur_pressed;
          suppress_release_next = 1'b0;
          cur_pressed_next      = ~item.pin_level;
          if (!long_flag) begin
            if (!cur_pressed_next && prev_pressed_next) begin
              if (ss_inc < cfg.double_window) begin
                double_flag_next = 1'b1;
              end else begin
                short_flag_next = 1'b1;
              end
              since_short_next = 16'd0;
              held_upd         = 8'd0;
            end else if (cur_pressed_next && prev_pressed_next) begin
              if (held_samples != 8'hFF) begin
                held_upd = held_samples + 8'd1;
              end
            end else begin
              held_upd = 8'd0;
            end
          end
          held_samples_next = held_upd;
          if (held_upd >= cfg.long_samples) begin
            long_flag_next        = cur_pressed_next;
            suppress_release_next = 1'b1;
          end
        end
      end
      OP_READ_SHORT: begin
        read_value      = {1'b0, short_flag};
        short_flag_next = 1'b0;
      end
      OP_READ_LONG: begin
        read_value     = {1'b0, long_flag};
        long_flag_next = 1'b0;
      end
      OP_READ_DOUBLE: begin
        read_value       = {1'b0, double_flag};
        double_flag_next = 1'b0;
      end
      OP_READ_ALT: begin
        if (double_flag) begin
          double_flag_next      = 1'b0;
          alternate_parity_next = ~alternate_parity;
          read_value            = alternate_parity ? ALT_SECOND : ALT_FIRST;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_counter   <= 8'd0;
      since_short      <= 16'd0;
      prev_pressed     <= 1'b0;
      cur_pressed      <= 1'b0;
      suppress_release <= 1'b0;
      held_samples     <= 8'd0;
      short_flag       <= 1'b0;
      long_flag        <= 1'b0;
      double_flag      <= 1'b0;
      alternate_parity <= 1'b0;
    end else if (fire) begin
      sample_counter   <= sample_counter_next;
      since_short      <= since_short_next;
      prev_pressed     <= prev_pressed_next;
      cur_pressed      <= cur_pressed_next;
      suppress_release <= suppress_release_next;
      held_samples     <= held_samples_next;
      short_flag       <= short_flag_next;
      long_flag        <= long_flag_next;
      double_flag      <= double_flag_next;
      alternate_parity <= alternate_parity_next;
    end
  end

  assign result.read_value     = read_value;
  assign result.short_pending  = short_flag_next;
  assign result.long_pending   = long_flag_next;
  assign result.double_pending = double_flag_next;
  assign result.key_sampled    = cur_pressed_next;

endmodule

// File: rtl/core/button_press_classifier.sv
// ---------------------------------------------------------------------------
// Button press classifier
// Short, long and double press detection for one active-low push button.
// ---------------------------------------------------------------------------
// Usage: each request on the input channel (in_valid, in_stall, in_data) is a
// tick carrying the raw pin level or a read that returns and clears one
// pending event flag. Every request produces exactly one result on the
// output channel (out_valid, out_stall, out_data) with the read value and
// the pending flags as they stand after the request.
// The input register captures a request and the result register its result.
// One request per cycle is sustained while the receiver does not stall; the
// state update is a single pass of short logic between the input register
// and the result register. When the receiver stalls, the result register
// holds and the input register takes one more request if empty, then in_stall
// rises until the result is taken. Configuration is written through cfg_we,
// cfg_index and cfg_data; the user must do so only while no request is in
// flight, which the block does not enforce. Reset clears all state, empties
// both registers and loads the default configuration.
// ---------------------------------------------------------------------------
`include "button_press_classifier_defines.svh"

module button_press_classifier (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bpc_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bpc_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bpc_pkg::*;

  cfg_t      cfg;
  logic      in_q_valid;
  in_item_t  item_q;
  logic      out_free;
  logic      fire;
  out_item_t result;

  assign out_free = !out_valid || !out_stall;
  assign fire     = in_q_valid && out_free;
  assign in_stall = in_q_valid && !out_free;

  bpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bpc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (fire),
    .item   (item_q),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_q_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= in_q_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_q <= in_data;
    end
    if (fire) begin
      out_data <= result;
    end
  end

  `BPC_ASSERT_SAME(a_stall_needs_full, clk, rst, in_stall, in_q_valid && out_valid)
  `BPC_ASSERT_NEXT(a_read_short_clears, clk, rst, fire && item_q.op == OP_READ_SHORT,
                   out_valid && !out_data.short_pending)
  `BPC_ASSERT_NEXT(a_tick_reads_zero, clk, rst, fire && item_q.op == OP_TICK,
                   out_valid && out_data.read_value == 2'd0)

endmodule
